FILE: hdl/masked_byte_pattern_scanner_unit_defines.svh
// Assertion helpers used by the scanner top level.
`ifndef MASKED_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MBPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define MBPS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/mbps_pkg.sv
`timescale 1ns / 1ps

package mbps_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	localparam logic [8:0]  LIMIT_CAP      = 9'd256;
	localparam logic [63:0] RST_PATTERN    = 64'd0;
	localparam logic [15:0] RST_CARE_MASK  = 16'hFFFF;
	localparam logic [4:0]  RST_PATTERN_LEN = 5'd1;
	localparam logic [8:0]  RST_MATCH_LIMIT = 9'd32;
	localparam logic [63:0] RST_REGION_BASE = 64'd0;

	typedef enum logic [2:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_CARE_MASK    = 3'd2,
		REG_PATTERN_LEN  = 3'd3,
		REG_MATCH_LIMIT  = 3'd4,
		REG_REGION_BASE  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        matched;
		logic [63:0] match_address;
		logic        limit_reached;
		logic        region_done;
	} out_item_t;

	// Settings as the scan datapath sees them: length and limit already clamped.
	typedef struct packed {
		logic [127:0] pattern;
		logic [15:0]  care;
		logic [4:0]   len;
		logic [8:0]   limit;
		logic [63:0]  base;
	} cfg_t;

endpackage

FILE: hdl/mbps_cfg.sv
`timescale 1ns / 1ps

module mbps_cfg #(
	parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mbps_pkg::ADDR_W-1:0] paddr,
	input  logic [mbps_pkg::DATA_W-1:0] pwdata,
	output logic [mbps_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output mbps_pkg::cfg_t              cfg
);
	import mbps_pkg::*;

	logic [63:0] pattern_low_q;
	logic [63:0] pattern_high_q;
	logic [15:0] care_mask_q;
	logic [4:0]  pattern_len_q;
	logic [8:0]  match_limit_q;
	logic [63:0] region_base_q;

	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= RST_PATTERN;
			pattern_high_q <= RST_PATTERN;
			care_mask_q    <= RST_CARE_MASK;
			pattern_len_q  <= RST_PATTERN_LEN;
			match_limit_q  <= RST_MATCH_LIMIT;
			region_base_q  <= RST_REGION_BASE;
		end else if (wr_en) begin
			unique case (idx)
				REG_PATTERN_LOW:  pattern_low_q  <= pwdata;
				REG_PATTERN_HIGH: pattern_high_q <= pwdata;
				REG_CARE_MASK:    care_mask_q    <= pwdata[15:0];
				REG_PATTERN_LEN:  pattern_len_q  <= pwdata[4:0];
				REG_MATCH_LIMIT:  match_limit_q  <= pwdata[8:0];
				REG_REGION_BASE:  region_base_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PATTERN_LOW:  prdata = pattern_low_q;
			REG_PATTERN_HIGH: prdata = pattern_high_q;
			REG_CARE_MASK:    prdata = {48'd0, care_mask_q};
			REG_PATTERN_LEN:  prdata = {59'd0, pattern_len_q};
			REG_MATCH_LIMIT:  prdata = {55'd0, match_limit_q};
			REG_REGION_BASE:  prdata = region_base_q;
			default:          prdata = '0;
		endcase
	end

	// Clamp length to 1..PATTERN_MAX and limit to the cap.
	always_comb begin
		cfg.pattern = {pattern_high_q, pattern_low_q};
		cfg.care    = care_mask_q;
		cfg.base    = region_base_q;
		if (pattern_len_q == 5'd0) begin
			cfg.len = 5'd1;
		end else if (pattern_len_q > 5'(PATTERN_MAX)) begin
			cfg.len = 5'(PATTERN_MAX);
		end else begin
			cfg.len = pattern_len_q;
		end
		cfg.limit = (match_limit_q > LIMIT_CAP) ? LIMIT_CAP : match_limit_q;
	end

endmodule

FILE: hdl/mbps_scan.sv
`timescale 1ns / 1ps

module mbps_scan #(
	parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbps_pkg::cfg_t      cfg,
	input  mbps_pkg::in_item_t  item,
	input  logic                advance,
	output logic                emit,
	output mbps_pkg::out_item_t res
);
	import mbps_pkg::*;

	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [7:0]             win_q   [PATTERN_MAX];
	logic [7:0]             win_new [PATTERN_MAX];
	logic [OFFSET_BITS-1:0] seen_q;
	logic [OFFSET_BITS-1:0] seen_cur;
	logic [OFFSET_BITS-1:0] seen_new;
	logic [8:0]             count_q;
	logic [8:0]             count_cur;
	logic [8:0]             count_new;
	logic                   counted;
	logic                   pat_ok;
	logic                   hit;

	// Shift the new byte in; a region start drops the old window.
	always_comb begin
		win_new[0] = item.data_byte;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_new[k] = item.first_byte ? 8'd0 : win_q[k-1];
		end
	end

	// Pattern byte j lines up with the byte that came len-1-j bytes ago.
	always_comb begin
		logic [IDX_W-1:0] idx;
		pat_ok = 1'b1;
		for (int j = 0; j < PATTERN_MAX; j++) begin
			idx = IDX_W'(int'(cfg.len) - 1 - j);
			if ((j < int'(cfg.len)) && cfg.care[j] &&
			    (win_new[idx] != cfg.pattern[8*j +: 8])) begin
				pat_ok = 1'b0;
			end
		end
	end

	always_comb begin
		seen_cur  = item.first_byte ? '0 : seen_q;
		count_cur = item.first_byte ? 9'd0 : count_q;
		counted   = (seen_cur != '1);
		seen_new  = counted ? seen_cur + OFFSET_BITS'(1) : seen_cur;
		hit       = counted && (seen_new >= OFFSET_BITS'(cfg.len)) &&
		            (count_cur < cfg.limit) && pat_ok;
		count_new = count_cur + {8'd0, hit};
	end

	assign emit              = hit || item.last_byte;
	assign res.matched       = hit;
	assign res.match_address = hit ? cfg.base + 64'(seen_new - OFFSET_BITS'(cfg.len)) : 64'd0;
	assign res.limit_reached = (count_new >= cfg.limit);
	assign res.region_done   = item.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= 8'd0;
			end
			seen_q  <= '0;
			count_q <= 9'd0;
		end else if (advance) begin
			win_q   <= win_new;
			seen_q  <= seen_new;
			count_q <= count_new;
		end
	end

endmodule

FILE: hdl/masked_byte_pattern_scanner_unit.sv
`timescale 1ns / 1ps
// Masked byte pattern scanner.
// Bytes of a memory region enter on the item channel (valid/stall), one per
// transfer, with first_byte on the region's first byte and last_byte on its
// last. Each byte yields zero or one result on the result channel: one when
// the window of the last pattern_len bytes matches the pattern under the care
// mask (match_address = region_base + offset of the window start), and one on
// the last byte with region_done set. Matches stop at match_limit per region.
// Throughput: one byte per cycle while the receiver does not stall. The byte
// goes into an input register, the masked compare over the PATTERN_MAX-byte
// window and the address add run on it there, and the result lands in the
// output register. When the receiver stalls, the pending result holds and
// one more byte may still be taken into the input register; further bytes
// then stall. Reset clears the window, byte count and match count and
// returns the registers to their defaults; no clearing pass is needed.
// Registers are written over the APB-style port at 8*index; the user must
// write them only while the scanner is idle: the block does not enforce it.
module masked_byte_pattern_scanner_unit #(
	parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mbps_pkg::ADDR_W-1:0] paddr,
	input  logic [mbps_pkg::DATA_W-1:0] pwdata,
	output logic [mbps_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  mbps_pkg::in_item_t          item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output mbps_pkg::out_item_t         result
);
	import mbps_pkg::*;

	`include "masked_byte_pattern_scanner_unit_defines.svh"

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      proc;
	logic      emit;
	out_item_t res_comb;
	out_item_t result_q;
	logic      result_valid_q;

	mbps_cfg #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	mbps_scan #(
		.PATTERN_MAX(PATTERN_MAX),
		.OFFSET_BITS(OFFSET_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.advance(proc),
		.emit   (emit),
		.res    (res_comb)
	);

	// Process the held byte when the output register is free or draining.
	assign proc       = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (proc && emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			result_q <= res_comb;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`MBPS_ASSERT_IMP(a_stall_needs_byte, item_stall, valid_s1, "stall with empty input stage")
	`MBPS_ASSERT_IMP(a_no_empty_result, result_valid, result.matched || result.region_done,
		"result with neither match nor region end")
	`MBPS_ASSERT_IMP(a_addr_zero, result_valid && !result.matched, result.match_address == 64'd0,
		"address set on a non-match result")
	`MBPS_ASSERT_NXT(a_byte_consumed, proc && !(item_valid && !item_stall), !valid_s1,
		"processed byte left in input stage")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mbps_pkg::*;

	localparam int          LONG_HOLD      = 64;
	localparam int          SETTLE_CYCLES  = 8;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam logic [63:0] OFFSET_SAT     = (64'd1 << OFFSET_BITS_DEF) - 64'd1;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                item_valid;
	logic                item_stall;
	in_item_t            item;
	logic                result_valid;
	logic                result_stall;
	out_item_t           result;

	// shadow of the scanner registers
	logic [127:0]        cfg_pattern = {RST_PATTERN, RST_PATTERN};
	logic [15:0]         cfg_care    = RST_CARE_MASK;
	logic [4:0]          cfg_len     = RST_PATTERN_LEN;
	logic [8:0]          cfg_limit   = RST_MATCH_LIMIT;
	logic [63:0]         cfg_base    = RST_REGION_BASE;

	// scan state: recent_bytes[0] is the newest byte
	logic [7:0]          recent_bytes [16];
	logic [63:0]         region_offset;
	logic [8:0]          region_hits;
	out_item_t           pending_reports [$];

	int unsigned         mismatches      = 0;
	int unsigned         bytes_sent      = 0;
	int unsigned         reports_checked = 0;
	int unsigned         matches_checked = 0;
	int unsigned         settings_loaded = 0;
	int unsigned         gap_pct         = 12;
	int unsigned         stall_pct       = 12;
	int unsigned         hold_req_id     = 0;

	masked_byte_pattern_scanner_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned window_len();
		if (cfg_len == 5'd0) return 1;
		if (cfg_len > 5'd16) return 16;
		return 32'(cfg_len);
	endfunction

	function automatic void scan_window_step(in_item_t it);
		int unsigned len, k, j;
		logic [8:0]  lim;
		logic        hit;
		logic [63:0] addr;
		out_item_t   rep;
		len = window_len();
		lim = (cfg_limit > LIMIT_CAP) ? LIMIT_CAP : cfg_limit;
		hit = 1'b0;
		addr = '0;
		if (it.first_byte) begin
			for (k = 0; k < 16; k++) recent_bytes[k] = 8'h00;
			region_offset = '0;
			region_hits = '0;
		end
		for (k = 15; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
		recent_bytes[0] = it.data_byte;
		// a saturated offset still shifts the window but never reports a match
		if (region_offset < OFFSET_SAT) begin
			region_offset = region_offset + 64'd1;
			if (region_offset >= 64'(len) && region_hits < lim) begin
				hit = 1'b1;
				for (j = 0; j < len; j++)
					if (cfg_care[j] && recent_bytes[len - 1 - j] != cfg_pattern[8*j +: 8])
						hit = 1'b0;
				if (hit) begin
					region_hits = region_hits + 9'd1;
					addr = cfg_base + (region_offset - 64'(len));
				end
			end
		end
		if (hit || it.last_byte) begin
			rep.matched = hit;
			rep.match_address = addr;
			rep.limit_reached = (region_hits >= lim);
			rep.region_done = it.last_byte;
			pending_reports = {pending_reports, rep};
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch on %s at report %0d: got %h, wanted %h",
			what, reports_checked, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			reports_checked++;
			if (pending_reports.size() == 0) begin
				report_mismatch("unexpected report", result.match_address, 64'd0);
			end else begin
				want = pending_reports.pop_front();
				if (want.matched) matches_checked++;
				if (result.matched !== want.matched)
					report_mismatch("matched", 64'(result.matched), 64'(want.matched));
				if (result.match_address !== want.match_address)
					report_mismatch("match_address", result.match_address,
						want.match_address);
				if (result.limit_reached !== want.limit_reached)
					report_mismatch("limit_reached", 64'(result.limit_reached),
						64'(want.limit_reached));
				if (result.region_done !== want.region_done)
					report_mismatch("region_done", 64'(result.region_done),
						64'(want.region_done));
			end
		end
	end

	// result side: random stall bursts, plus a long hold on request
	initial begin : result_side
		int unsigned hold_seen, n;
		hold_seen = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req_id != hold_seen) begin
				hold_seen = hold_req_id;
				result_stall <= 1'b1;
				for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
				result_stall <= 1'b0;
			end else if ($urandom_range(1, 100) <= stall_pct) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PATTERN_LOW:  cfg_pattern[63:0] = value;
			REG_PATTERN_HIGH: cfg_pattern[127:64] = value;
			REG_CARE_MASK:    cfg_care = value[15:0];
			REG_PATTERN_LEN:  cfg_len = value[4:0];
			REG_MATCH_LIMIT:  cfg_limit = value[8:0];
			REG_REGION_BASE:  cfg_base = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [63:0] pat_lo, input logic [63:0] pat_hi,
			input logic [15:0] care_bits, input logic [4:0] len_code,
			input logic [8:0] limit_code, input logic [63:0] base);
		write_reg(REG_PATTERN_LOW, pat_lo);
		write_reg(REG_PATTERN_HIGH, pat_hi);
		write_reg(REG_CARE_MASK, {48'd0, care_bits});
		write_reg(REG_PATTERN_LEN, {59'd0, len_code});
		write_reg(REG_MATCH_LIMIT, {55'd0, limit_code});
		write_reg(REG_REGION_BASE, base);
		settings_loaded++;
	endtask

	task automatic push_byte(input logic [7:0] data, input logic first, input logic last);
		in_item_t next_item;
		next_item.data_byte = data;
		next_item.first_byte = first;
		next_item.last_byte = last;
		if ($urandom_range(1, 100) <= gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= next_item;
		do @(posedge clk); while (item_stall);
		scan_window_step(next_item);
		bytes_sent++;
	endtask

	// drop valid, wait out every report, then let the pipeline empty
	task automatic drain_and_settle();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random region with planted pattern copies; a broken one has stray markers
	task automatic send_region(input int unsigned nbytes, input int unsigned plant_pct,
			input logic broken);
		logic [7:0]  region_bytes [$];
		int unsigned i, j, pos, len;
		logic        first, last;
		len = window_len();
		region_bytes = {};
		for (i = 0; i < nbytes; i++)
			region_bytes = {region_bytes, 8'($urandom_range(0, 255))};
		for (pos = 0; pos + len <= nbytes; pos++)
			if ($urandom_range(0, 99) < plant_pct)
				for (j = 0; j < len; j++)
					if (cfg_care[j]) region_bytes[pos + j] = cfg_pattern[8*j +: 8];
		for (i = 0; i < nbytes; i++) begin
			first = (i == 0);
			last = (i == nbytes - 1);
			if (broken && $urandom_range(0, 3) == 0) first = 1'($urandom_range(0, 1));
			if (broken && $urandom_range(0, 3) == 0) last = 1'($urandom_range(0, 1));
			push_byte(region_bytes[i], first, last);
		end
	endtask

	task automatic run_regions(input int unsigned n_items, input int unsigned lo,
			input int unsigned hi, input int unsigned plant_pct);
		int unsigned stop_at;
		stop_at = bytes_sent + n_items;
		while (bytes_sent < stop_at)
			send_region($urandom_range(lo, hi), plant_pct, $urandom_range(0, 9) == 0);
	endtask

	// scan straight out of reset with no first_byte marker, default settings
	task automatic test_unregioned_start();
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h7F, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b1);
		drain_and_settle();
	endtask

	// FF ?? 00 with stray care bits past the length, overlap, limit of 2, base wrap
	task automatic test_wildcard_overlap_wrap();
		load_settings(64'hA5A5_A5A5_A500_5AFF, '1, 16'hFFFD, 5'd3, 9'd2,
			64'hFFFF_FFFF_FFFF_FFFE);
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte(8'h11, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h22, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h33, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h80, 1'b0, 1'b0);
		push_byte(8'h01, 1'b0, 1'b1);
		push_byte(8'hFF, 1'b1, 1'b1);
		drain_and_settle();
	endtask

	task automatic test_length_clamps();
		load_settings({$urandom, $urandom}, {$urandom, $urandom}, 16'h0001, 5'd0, 9'd32,
			64'd0);
		run_regions(80, 1, 30, 30);
		drain_and_settle();
		load_settings({$urandom, $urandom}, {$urandom, $urandom},
			16'($urandom_range(0, 65535)), 5'd31, 9'd32, {$urandom, $urandom});
		run_regions(80, 1, 40, 40);
		drain_and_settle();
		load_settings({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd17, 9'd16,
			{$urandom, $urandom});
		run_regions(80, 1, 40, 40);
		drain_and_settle();
	endtask

	task automatic test_limit_clamps();
		// everything would match: a zero limit must still report no match
		load_settings('1, '1, 16'h0000, 5'd2, 9'd0, {$urandom, $urandom});
		run_regions(80, 1, 20, 0);
		drain_and_settle();
		load_settings('0, '0, 16'h0000, 5'd2, 9'h1FF, '1);
		send_region(290, 0, 1'b0);
		drain_and_settle();
		load_settings({$urandom, $urandom}, {$urandom, $urandom}, 16'h00FF, 5'd4, 9'd1,
			{$urandom, $urandom});
		run_regions(80, 1, 30, 40);
		drain_and_settle();
	endtask

	task automatic test_full_window();
		load_settings({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd16, 9'd256,
			{$urandom, $urandom});
		run_regions(100, 16, 60, 40);
		drain_and_settle();
	endtask

	task automatic test_backpressure();
		gap_pct = 0;
		load_settings({$urandom, $urandom}, '0, 16'h0000, 5'd1, 9'd256, {$urandom, $urandom});
		run_regions(40, 10, 30, 0);
		hold_req_id <= hold_req_id + 1;
		run_regions(60, 10, 30, 0);
		drain_and_settle();
		run_regions(50, 10, 30, 0);
		drain_and_settle();
		gap_pct = 12;
	endtask

	task automatic random_settings();
		logic [7:0]  fill;
		logic [63:0] lo, hi;
		logic [8:0]  lim;
		fill = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 2) == 0) begin
			lo = {8{fill}};
			hi = lo;
		end else begin
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
		end
		if ($urandom_range(0, 3) == 0) lim = 9'($urandom_range(0, 511));
		else lim = 9'($urandom_range(1, 12));
		load_settings(lo, hi, 16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)), lim,
			{$urandom, $urandom});
	endtask

	task automatic test_random_mix();
		int unsigned n;
		for (n = 0; n < 5; n++) begin
			gap_pct = $urandom_range(0, 25);
			stall_pct = $urandom_range(0, 25);
			random_settings();
			run_regions(60, 1, 40, 25);
			drain_and_settle();
		end
	endtask

	task automatic test_steady_stream();
		gap_pct = 0;
		stall_pct = 0;
		random_settings();
		run_regions(150, 1, 40, 25);
		drain_and_settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_valid <= 1'b0;
		item <= '0;
		for (int k = 0; k < 16; k++) recent_bytes[k] = 8'h00;
		region_offset = '0;
		region_hits = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unregioned_start();
		test_wildcard_overlap_wrap();
		test_length_clamps();
		test_limit_clamps();
		test_full_window();
		test_backpressure();
		test_random_mix();
		test_steady_stream();

		$display("scanned %0d bytes under %0d register settings", bytes_sent, settings_loaded);
		$display("checked %0d reports, %0d of them matches", reports_checked, matches_checked);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
